### rtl/core/whrd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the hit-rate detect qualifier.
package whrd_pkg;

	// Default depth of the hit window.
	localparam int MAX_WINDOW = 64;

	// Fixed field widths.
	localparam int WLEN_W   = 7;
	localparam int NEED_W   = 7;
	localparam int WARM_W   = 16;
	localparam int DET_W    = 4;
	localparam int FRAME_W  = 17;
	localparam int STREAK_W = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Saturation limits of the frame and empty-streak counters.
	localparam logic [FRAME_W-1:0]  FRAME_MAX  = '1;
	localparam logic [STREAK_W-1:0] STREAK_MAX = '1;

	// Register reset values.
	localparam logic [WLEN_W-1:0] WLEN_RST = 7'd8;
	localparam logic [NEED_W-1:0] NEED_RST = 7'd6;
	localparam logic [WARM_W-1:0] WARM_RST = 16'd20;
	localparam logic [DET_W-1:0]  REQ_RST  = 4'd2;
	localparam logic              FEN_RST  = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LEN       = 3'd0,
		CFG_HITS_NEEDED      = 3'd1,
		CFG_WARMUP_FRAMES    = 3'd2,
		CFG_REQUIRED_DETECTS = 3'd3,
		CFG_FIRE_ENABLE      = 3'd4
	} cfg_idx_t;

	// One result beat.
	typedef struct packed {
		logic              fire;
		logic [DET_W-1:0]  detect_number;
		logic              finished;
		logic              warming_up;
		logic              waiting_clear;
		logic [6:0]        window_hits;
	} whrd_result_t;

	// Per-cycle control broadcast to every window cell.
	typedef struct packed {
		logic shift;
		logic clear;
		logic drop;
	} whrd_cell_ctl_t;

endpackage

### rtl/core/whrd_cell.sv
`timescale 1ns / 1ps
// One cell of the hit window: holds one history bit and hands it to the next cell.
module whrd_cell #(
	parameter int IDX    = 0,
	parameter int FILL_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  whrd_pkg::whrd_cell_ctl_t ctl,
	input  logic [FILL_W-1:0]       fill,
	input  logic                    prev_bit,
	output logic                    next_bit,
	output logic                    tap
);

	localparam logic [FILL_W-1:0] OLDEST_FILL = FILL_W'(IDX + 1);

	logic bit_q;
	logic is_oldest;

	// This cell holds the oldest entry when the fill count points just past it.
	assign is_oldest = (fill == OLDEST_FILL);
	assign tap       = bit_q & is_oldest;

	// A dropped oldest entry reaches the neighbor as an empty slot.
	assign next_bit = bit_q & ~(ctl.drop & is_oldest);

	// History bit: cleared on a window clear, shifted in on a window update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.shift) begin
			bit_q <= prev_bit;
		end
	end

endmodule

### rtl/core/whrd_outbuf.sv
`timescale 1ns / 1ps
// Two-entry output buffer (output register plus skid slot) for result beats.
module whrd_outbuf (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  whrd_pkg::whrd_result_t push_data,
	output logic                   full,
	output logic                   out_valid,
	input  logic                   out_stall,
	output whrd_pkg::whrd_result_t out_data
);

	logic                   out_valid_q;
	logic                   skid_valid_q;
	whrd_pkg::whrd_result_t out_data_q;
	whrd_pkg::whrd_result_t skid_data_q;
	logic                   out_free;

	assign out_free  = ~out_valid_q | ~out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Control: the skid slot fills only while the output register is held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves with the control above.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

### rtl/core/windowed_hit_rate_detect_qualifier.sv
`timescale 1ns / 1ps
// Top level of the windowed hit-rate detect qualifier.
// Takes one frame_hit bit per input beat and returns exactly one result beat
// for it. An input beat can be accepted on every clock unless in_stall is high:
// the window is a row of MAX_WINDOW one-bit cells that all shift together, and
// the counters beside it update in the same cycle, so the result is registered
// into the output buffer on acceptance. Results pass through a two-entry output
// buffer; in_stall rises only when both entries hold results that are not yet taken.
// Configuration writes take effect on the next accepted beat and should be
// made while no results are outstanding.
module windowed_hit_rate_detect_qualifier #(
	parameter int MAX_WINDOW = whrd_pkg::MAX_WINDOW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [whrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [whrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              frame_hit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              fire,
	output logic [whrd_pkg::DET_W-1:0]        detect_number,
	output logic                              finished,
	output logic                              warming_up,
	output logic                              waiting_clear,
	output logic [6:0]                        window_hits
);

	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int CW = (FW > whrd_pkg::WLEN_W) ? FW : whrd_pkg::WLEN_W;
	localparam logic [CW-1:0] MAX_X = CW'(MAX_WINDOW);
	localparam logic [CW-1:0] ONE_X = CW'(1);

	// Configuration registers.
	logic [whrd_pkg::WLEN_W-1:0]   window_len_q;
	logic [whrd_pkg::NEED_W-1:0]   hits_needed_q;
	logic [whrd_pkg::WARM_W-1:0]   warmup_frames_q;
	logic [whrd_pkg::DET_W-1:0]    required_detects_q;
	logic                          fire_enable_q;

	// Detector state.
	logic [FW-1:0]                 fill_q;
	logic [FW-1:0]                 hit_cnt_q;
	logic [whrd_pkg::FRAME_W-1:0]  frame_q;
	logic [whrd_pkg::STREAK_W-1:0] streak_q;
	logic                          awaiting_q;
	logic [whrd_pkg::DET_W-1:0]    detect_q;
	logic                          done_q;

	// Next-state values.
	logic [FW-1:0]                 fill_n;
	logic [FW-1:0]                 hit_cnt_n;
	logic [whrd_pkg::FRAME_W-1:0]  frame_inc;
	logic [whrd_pkg::STREAK_W-1:0] streak_inc;
	logic [whrd_pkg::STREAK_W-1:0] streak_n;
	logic                          awaiting_n;
	logic [whrd_pkg::DET_W-1:0]    detect_n;
	logic                          done_n;
	logic                          fire_n;

	logic                          accept;
	logic                          warm;
	logic                          counting;
	logic [CW-1:0]                 win_x;
	logic [CW-1:0]                 wlen_x;
	logic [CW-1:0]                 need_x;
	logic                          drop;
	logic                          oldest_hit;
	logic [FW-1:0]                 hit_after_drop;
	logic [FW-1:0]                 hit_after_add;
	logic [FW-1:0]                 fill_after_add;
	logic                          threshold;
	logic                          rearm;

	whrd_pkg::whrd_cell_ctl_t      cell_ctl;
	whrd_pkg::whrd_result_t        result;
	whrd_pkg::whrd_result_t        out_res;

	logic [MAX_WINDOW:0]           chain;
	logic [MAX_WINDOW-1:0]         taps;

	assign accept = in_valid & ~in_stall;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q       <= whrd_pkg::WLEN_RST;
			hits_needed_q      <= whrd_pkg::NEED_RST;
			warmup_frames_q    <= whrd_pkg::WARM_RST;
			required_detects_q <= whrd_pkg::REQ_RST;
			fire_enable_q      <= whrd_pkg::FEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				whrd_pkg::CFG_WINDOW_LEN:       window_len_q <= cfg_data[6:0];
				whrd_pkg::CFG_HITS_NEEDED:      hits_needed_q <= cfg_data[6:0];
				whrd_pkg::CFG_WARMUP_FRAMES:    warmup_frames_q <= cfg_data;
				whrd_pkg::CFG_REQUIRED_DETECTS: required_detects_q <= cfg_data[3:0];
				whrd_pkg::CFG_FIRE_ENABLE:      fire_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Effective window length and threshold after clamping.
	assign wlen_x = CW'(window_len_q);
	assign win_x  = (window_len_q == '0) ? ONE_X : ((wlen_x > MAX_X) ? MAX_X : wlen_x);
	assign need_x = (hits_needed_q == '0) ? ONE_X : CW'(hits_needed_q);

	// Saturating counters.
	assign frame_inc  = (frame_q != whrd_pkg::FRAME_MAX) ? frame_q + 1'b1 : frame_q;
	assign streak_inc = (streak_q != whrd_pkg::STREAK_MAX) ? streak_q + 1'b1 : streak_q;
	assign warm       = frame_inc <= {1'b0, warmup_frames_q};
	assign counting   = ~done_q & ~warm;

	// Window update arithmetic.
	assign oldest_hit     = |taps;
	assign drop           = CW'(fill_q) >= win_x;
	assign hit_after_drop = hit_cnt_q - FW'(drop & oldest_hit);
	assign hit_after_add  = hit_after_drop + FW'(frame_hit);
	assign fill_after_add = drop ? fill_q : fill_q + 1'b1;
	assign threshold      = fire_enable_q & (CW'(hit_after_add) >= need_x);
	assign rearm          = ~frame_hit & (CW'(streak_inc) >= win_x);

	// Next state for one frame.
	always_comb begin
		fill_n     = fill_q;
		hit_cnt_n  = hit_cnt_q;
		streak_n   = streak_q;
		awaiting_n = awaiting_q;
		detect_n   = detect_q;
		done_n     = done_q;
		fire_n     = 1'b0;
		cell_ctl   = '0;
		if (counting) begin
			if (awaiting_q) begin
				if (!frame_hit) begin
					streak_n = streak_inc;
					if (rearm) begin
						awaiting_n     = 1'b0;
						streak_n       = '0;
						fill_n         = '0;
						hit_cnt_n      = '0;
						cell_ctl.clear = 1'b1;
					end
				end else begin
					streak_n = '0;
				end
			end else begin
				cell_ctl.shift = 1'b1;
				cell_ctl.drop  = drop;
				fill_n         = fill_after_add;
				hit_cnt_n      = hit_after_add;
				if (threshold) begin
					done_n = 1'b1;
					if (detect_q < required_detects_q) begin
						detect_n = detect_q + 1'b1;
						fire_n   = 1'b1;
						done_n   = (detect_q + 1'b1) >= required_detects_q;
					end
					awaiting_n     = ~done_n;
					streak_n       = '0;
					fill_n         = '0;
					hit_cnt_n      = '0;
					cell_ctl.clear = 1'b1;
				end
			end
		end
		if (!accept) begin
			cell_ctl = '0;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			hit_cnt_q  <= '0;
			frame_q    <= '0;
			streak_q   <= '0;
			awaiting_q <= 1'b0;
			detect_q   <= '0;
			done_q     <= 1'b0;
		end else if (accept) begin
			fill_q     <= fill_n;
			hit_cnt_q  <= hit_cnt_n;
			streak_q   <= streak_n;
			awaiting_q <= awaiting_n;
			detect_q   <= detect_n;
			done_q     <= done_n;
			if (!done_q) begin
				frame_q <= frame_inc;
			end
		end
	end

	// Row of window cells, newest entry in cell zero.
	assign chain[0] = frame_hit;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		whrd_cell #(
			.IDX    (i),
			.FILL_W (FW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (cell_ctl),
			.fill     (fill_q),
			.prev_bit (chain[i]),
			.next_bit (chain[i+1]),
			.tap      (taps[i])
		);
	end

	// Result beat for this frame.
	always_comb begin
		result.fire          = fire_n;
		result.detect_number = detect_n;
		result.finished      = done_n;
		result.warming_up    = ~done_q & warm;
		result.waiting_clear = awaiting_n & ~done_n;
		result.window_hits   = 7'(hit_cnt_n);
	end

	whrd_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign fire          = out_res.fire;
	assign detect_number = out_res.detect_number;
	assign finished      = out_res.finished;
	assign warming_up    = out_res.warming_up;
	assign waiting_clear = out_res.waiting_clear;
	assign window_hits   = out_res.window_hits;

	// The window never counts more hits than it holds entries.
	a_hits_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		hit_cnt_q <= fill_q)
		else $error("window hit count exceeds fill count");

	// The fill count stays within the cell row.
	a_fill_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= MAX_X)
		else $error("window fill count beyond cell row");

	// Once finished, the block stays finished.
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q)
		else $error("finished flag dropped");

	// A fired detection always carries a nonzero detection number.
	a_fire_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fire) |-> (detect_number != '0))
		else $error("fire beat with zero detection number");

endmodule

### verif/whrd_qualify_checker.sv
`timescale 1ns / 1ps
// Checker that predicts every result beat of the hit-rate qualifier and compares it.
module whrd_qualify_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [whrd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [whrd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic                            frame_hit,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            fire,
	input  logic [whrd_pkg::DET_W-1:0]      detect_number,
	input  logic                            finished,
	input  logic                            warming_up,
	input  logic                            waiting_clear,
	input  logic [6:0]                      window_hits,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int PEND_DEPTH = 16;

	// Shadow copy of the configuration registers.
	logic [whrd_pkg::WLEN_W-1:0] win_len_r;
	logic [whrd_pkg::NEED_W-1:0] need_r;
	logic [whrd_pkg::WARM_W-1:0] warm_r;
	logic [whrd_pkg::DET_W-1:0]  req_r;
	logic                        fen_r;

	// Predicted window and counter state.
	logic [whrd_pkg::MAX_WINDOW-1:0] hit_row;
	int unsigned                     row_fill;
	int unsigned                     row_hits;
	int unsigned                     frames_seen;
	int unsigned                     quiet_run;
	logic [whrd_pkg::DET_W-1:0]      detections;
	bit                              rearm_wait;
	bit                              retired;

	// Predicted results waiting for their beat, kept in a small ring.
	whrd_pkg::whrd_result_t pend_verdicts [PEND_DEPTH];
	logic [3:0]             pend_rd;
	logic [3:0]             pend_wr;
	int                     pend_cnt;
	whrd_pkg::whrd_result_t want;
	int                     errs;

	function automatic void clear_row();
		hit_row = '0;
		row_fill = 0;
		row_hits = 0;
	endfunction

	// Advances the predicted state by one frame and returns the result it should give.
	function automatic whrd_pkg::whrd_result_t qualify_frame(input logic hit);
		whrd_pkg::whrd_result_t res;
		int unsigned            span;
		int unsigned            need;
		bit                     warm;
		bit                     fired;
		bit                     stop;
		span = win_len_r;
		if (span < 1) span = 1;
		if (span > whrd_pkg::MAX_WINDOW) span = whrd_pkg::MAX_WINDOW;
		need = (need_r == 0) ? 1 : need_r;
		warm = 1'b0;
		fired = 1'b0;
		if (!retired) begin
			if (frames_seen < whrd_pkg::FRAME_MAX) frames_seen++;
			warm = (frames_seen <= warm_r);
			if (!warm) begin
				if (rearm_wait) begin
					// Count the run of empty frames; a hit starts it over.
					if (!hit) begin
						if (quiet_run < whrd_pkg::STREAK_MAX) quiet_run++;
						if (quiet_run >= span) begin
							rearm_wait = 1'b0;
							quiet_run = 0;
							clear_row();
						end
					end else begin
						quiet_run = 0;
					end
				end else begin
					// Drop the oldest bit when the window is already full.
					if (row_fill >= span && row_fill > 0) begin
						if (hit_row[row_fill-1]) row_hits--;
						hit_row[row_fill-1] = 1'b0;
						row_fill--;
					end
					hit_row = {hit_row[whrd_pkg::MAX_WINDOW-2:0], hit};
					row_fill++;
					if (hit) row_hits++;

					// Threshold reached: fire if detections remain, else finish quietly.
					if (fen_r && row_hits >= need) begin
						stop = 1'b1;
						if (detections < req_r) begin
							detections = detections + 1'b1;
							fired = 1'b1;
							stop = (detections >= req_r);
						end
						clear_row();
						rearm_wait = !stop;
						quiet_run = 0;
						if (stop) retired = 1'b1;
					end
				end
			end
		end
		res.fire = fired;
		res.detect_number = detections;
		res.finished = retired;
		res.warming_up = warm;
		res.waiting_clear = rearm_wait && !retired;
		res.window_hits = row_hits[6:0];
		return res;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (exp_val !== act_val) begin
			errs++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
				act_val);
		end
	endtask

	// Track register writes, predict on each input beat, compare each result beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_r = whrd_pkg::WLEN_RST;
			need_r = whrd_pkg::NEED_RST;
			warm_r = whrd_pkg::WARM_RST;
			req_r = whrd_pkg::REQ_RST;
			fen_r = whrd_pkg::FEN_RST;
			clear_row();
			frames_seen = 0;
			quiet_run = 0;
			detections = '0;
			rearm_wait = 1'b0;
			retired = 1'b0;
			pend_rd = '0;
			pend_wr = '0;
			pend_cnt = 0;
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					whrd_pkg::CFG_WINDOW_LEN:
						win_len_r = cfg_data[whrd_pkg::WLEN_W-1:0];
					whrd_pkg::CFG_HITS_NEEDED:
						need_r = cfg_data[whrd_pkg::NEED_W-1:0];
					whrd_pkg::CFG_WARMUP_FRAMES:
						warm_r = cfg_data[whrd_pkg::WARM_W-1:0];
					whrd_pkg::CFG_REQUIRED_DETECTS:
						req_r = cfg_data[whrd_pkg::DET_W-1:0];
					whrd_pkg::CFG_FIRE_ENABLE:
						fen_r = cfg_data[0];
					default: ;
				endcase
			end

			// Compare before queueing, so a beat can never match an item of the same edge.
			if (out_valid && !out_stall) begin
				if (pend_cnt == 0) begin
					errs++;
					$display({"%0t ns: result beat with no frame pending, expected none, ",
						"actual fire %0b detect_number %0d window_hits %0d"},
						$time, fire, detect_number, window_hits);
				end else begin
					want = pend_verdicts[pend_rd];
					pend_rd = pend_rd + 1'b1;
					pend_cnt--;
					check_field("fire", want.fire, fire);
					check_field("detect_number", want.detect_number, detect_number);
					check_field("finished", want.finished, finished);
					check_field("warming_up", want.warming_up, warming_up);
					check_field("waiting_clear", want.waiting_clear, waiting_clear);
					check_field("window_hits", want.window_hits, window_hits);
				end
			end

			if (in_valid && !in_stall) begin
				if (pend_cnt == PEND_DEPTH) begin
					errs++;
					$display("%0t ns: frames pending, expected at most %0d, actual %0d",
						$time, PEND_DEPTH, pend_cnt + 1);
				end else begin
					pend_verdicts[pend_wr] = qualify_frame(frame_hit);
					pend_wr = pend_wr + 1'b1;
					pend_cnt++;
				end
			end

			outstanding <= pend_cnt;
			mismatches <= errs;
		end
	end

endmodule

### verif/windowed_hit_rate_detect_qualifier_test.sv
`timescale 1ns / 1ps
// Testbench top for the hit-rate detect qualifier: clock, reset, stimulus and verdict.
module windowed_hit_rate_detect_qualifier_test;

	localparam int IDLE_LIMIT    = 2000;
	localparam int LONG_HOLD     = 120;
	localparam int RANDOM_FRAMES = 1900;
	localparam int IDX_W         = whrd_pkg::CFG_IDX_W;
	localparam int DATA_W        = whrd_pkg::CFG_DATA_W;
	localparam int MAX_WIN       = whrd_pkg::MAX_WINDOW;
	localparam int LAST_REG      = int'(whrd_pkg::CFG_FIRE_ENABLE);
	localparam int UNUSED_SPAN   = (1 << IDX_W) - 1 - LAST_REG;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [IDX_W-1:0]             cfg_index = whrd_pkg::CFG_WINDOW_LEN;
	logic [DATA_W-1:0]            cfg_data = '0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic                         frame_hit = 1'b0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic                         fire;
	logic [whrd_pkg::DET_W-1:0]   detect_number;
	logic                         finished;
	logic                         warming_up;
	logic                         waiting_clear;
	logic [6:0]                   window_hits;

	int mismatches;
	int outstanding;
	int fires_seen = 0;
	int idle_cycles = 0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	bit rx_hold_off = 1'b0;

	always #5 clk = ~clk;

	windowed_hit_rate_detect_qualifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_hit     (frame_hit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fire          (fire),
		.detect_number (detect_number),
		.finished      (finished),
		.warming_up    (warming_up),
		.waiting_clear (waiting_clear),
		.window_hits   (window_hits)
	);

	whrd_qualify_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.frame_hit     (frame_hit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.fire          (fire),
		.detect_number (detect_number),
		.finished      (finished),
		.warming_up    (warming_up),
		.waiting_clear (waiting_clear),
		.window_hits   (window_hits),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Fires seen so far decide how many more the stimulus may provoke before the finish.
	always @(posedge clk) begin
		if (out_valid && !out_stall && fire === 1'b1) fires_seen++;
	end

	// Watchdog: too long without any beat or register write means the block hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Result side: stall ahead of each beat, for a random or a long hold.
	initial begin
		int hold;
		forever begin
			if (rx_hold_off) begin
				hold = LONG_HOLD;
				rx_hold_off = 1'b0;
			end else begin
				hold = rx_quiet ? 0 : $urandom_range(0, 14);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Offers one frame after a random gap and returns at the edge that takes it.
	task automatic send_frame(input logic hit);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_hit <= hit;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Stops offering and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes all registers, then one index with no register behind it.
	task automatic program_regs(input int wl, input int need, input int warm, input int req,
			input int fen);
		cfg_we <= 1'b1;
		cfg_index <= whrd_pkg::CFG_WINDOW_LEN;
		cfg_data <= DATA_W'(wl);
		@(posedge clk);
		cfg_index <= whrd_pkg::CFG_HITS_NEEDED;
		cfg_data <= DATA_W'(need);
		@(posedge clk);
		cfg_index <= whrd_pkg::CFG_WARMUP_FRAMES;
		cfg_data <= DATA_W'(warm);
		@(posedge clk);
		cfg_index <= whrd_pkg::CFG_REQUIRED_DETECTS;
		cfg_data <= DATA_W'(req);
		@(posedge clk);
		cfg_index <= whrd_pkg::CFG_FIRE_ENABLE;
		cfg_data <= DATA_W'(fen);
		@(posedge clk);
		cfg_index <= IDX_W'(LAST_REG + 1 + $urandom_range(0, UNUSED_SPAN - 1));
		cfg_data <= DATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int wl;
		int eff;
		int need;
		int warm;
		int req;
		int fen;
		int plen;
		int pct;
		int budget;
		int phase;
		int useful;
		useful = 0;
		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: the warmup frames change nothing, then six hits fire once.
		for (int i = 0; i < 20; i++) send_frame(i % 3 == 0);
		repeat (6) send_frame(1'b1);
		drain();

		// Random phases. Each stays short enough with firing on that the run cannot
		// reach its required count before the closing phase.
		while (useful < RANDOM_FRAMES) begin
			case ($urandom_range(0, 9))
				0:       wl = 0;
				1:       wl = 1;
				2:       wl = MAX_WIN;
				3:       wl = $urandom_range(MAX_WIN + 1, 127);
				4:       wl = $urandom_range(17, MAX_WIN - 1);
				default: wl = $urandom_range(2, 16);
			endcase
			eff = (wl < 1) ? 1 : (wl > MAX_WIN) ? MAX_WIN : wl;
			case ($urandom_range(0, 7))
				0:       need = 0;
				1:       need = 127;
				2:       need = eff;
				default: need = $urandom_range(1, (eff + 1) / 2);
			endcase
			warm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2500) : 0;
			plen = $urandom_range(16, 64);
			budget = 2 * (13 - fires_seen) - 1;
			fen = (budget >= 4 && $urandom_range(0, 1) == 1);
			if (fen) begin
				if (plen > budget) plen = budget;
				req = $urandom_range(fires_seen + (plen + 1) / 2 + 1, 15);
			end else begin
				req = $urandom_range(0, 15);
			end
			pct = $urandom_range(0, 100);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);

			// One phase floods the block while the result side holds off.
			if (phase == 2) begin
				tx_quiet = 1'b1;
				rx_hold_off = 1'b1;
			end

			program_regs(wl, need, warm, req, fen);
			repeat (plen) send_frame($urandom_range(1, 100) <= pct);
			useful += plen;
			drain();
			phase++;
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;

		// Largest warmup: every later frame lies inside the warmup period again.
		program_regs(2, 1, 65535, 15, 1);
		repeat (12) send_frame(1'($urandom_range(0, 1)));
		drain();

		// Closing phase: either one last fire reaches the required count, or the count
		// is lowered so the threshold finishes the run without firing.
		req = ($urandom_range(0, 1) == 1) ? fires_seen + 1 : $urandom_range(0, fires_seen);
		program_regs(2, 1, 0, req, 1);
		repeat (3) send_frame(1'b0);
		send_frame(1'b1);

		// Frames after the finish are ignored.
		repeat (6) send_frame(1'($urandom_range(0, 1)));
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
